// File: rtl/core/cef_pkg.sv
// Shared types and codes for the coalescing event FIFO.
package cef_pkg;

  // Command codes on func
  localparam logic [1:0] FN_POST = 2'd0;
  localparam logic [1:0] FN_FOLD = 2'd1;
  localparam logic [1:0] FN_POP  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN
  } state_t;

  // Slot memory control
  typedef struct packed {
    logic rd_en;    // read all fields at rd_addr
    logic wr_all;   // write type, target and payload at wr_addr
    logic wr_pay;   // write payload only at wr_addr
  } mem_ctl_t;

endpackage

// File: rtl/core/cef_slot_mem.sv
// Slot storage: type, target and payload arrays with one registered read port.
module cef_slot_mem #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic               clk,
  input  cef_pkg::mem_ctl_t  ctl,
  input  logic [IDX_W-1:0]   rd_addr,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [31:0]        wr_type,
  input  logic [31:0]        wr_target,
  input  logic [31:0]        wr_payload,
  output logic [31:0]        rd_type,
  output logic [31:0]        rd_target,
  output logic [31:0]        rd_payload
);
  import cef_pkg::*;

  logic [31:0] mem_type    [DEPTH];
  logic [31:0] mem_target  [DEPTH];
  logic [31:0] mem_payload [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_all) begin
      mem_type[wr_addr]   <= wr_type;
      mem_target[wr_addr] <= wr_target;
    end
    if (ctl.wr_all || ctl.wr_pay) begin
      mem_payload[wr_addr] <= wr_payload;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_type    <= mem_type[rd_addr];
      rd_target  <= mem_target[rd_addr];
      rd_payload <= mem_payload[rd_addr];
    end
  end

endmodule

// File: rtl/core/coalescing_event_fifo_unit.sv
// Top level of the coalescing event FIFO: command sequencer around the slot memory.
//
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------------
//  command  | start / busy         | func, event_type, event_target, event_payload
//  result   | done (1-cycle pulse) | status, out_type, out_target, out_payload,
//           |                      | merged, dropped
//
// Post, pop or fold on empty, unused codes: result in the cycle after accept.
// Pop: one slot memory read at accept, then ST_POP registers the result.
// Fold: the scan reads one queued slot per cycle through the single read port.
// busy is high while a pop or fold is in flight; done never waits on the receiver.
// Reset (rst, synchronous) empties the queue; slot contents are not cleared.
module coalescing_event_fifo_unit #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] event_type,
  input  logic [31:0] event_target,
  input  logic [31:0] event_payload,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] out_type,
  output logic [31:0] out_target,
  output logic [31:0] out_payload,
  output logic        merged,
  output logic        dropped
);
  import cef_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  state_t state, state_next;

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] occ, occ_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic [31:0] cmd_type, cmd_target, cmd_payload;

  logic        done_next;
  logic [1:0]  status_next;
  logic [31:0] out_type_next, out_target_next, out_payload_next;
  logic        merged_next, dropped_next;

  mem_ctl_t         mctl;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [31:0]      wr_type, wr_target, wr_payload;
  logic [31:0]      rd_type, rd_target, rd_payload;

  logic accept;
  logic is_full;
  logic is_empty;
  logic hit;
  logic last_cmp;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (occ == FULL_CNT);
  assign is_empty = (occ == '0);
  assign hit      = (rd_type == cmd_type);
  assign last_cmp = (CNT_W'(cnt + 1'b1) == occ);

  cef_slot_mem #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_slot_mem (
    .clk        (clk),
    .ctl        (mctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_type    (wr_type),
    .wr_target  (wr_target),
    .wr_payload (wr_payload),
    .rd_type    (rd_type),
    .rd_target  (rd_target),
    .rd_payload (rd_payload)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FN_POP && !is_empty) begin
            state_next = ST_POP;
          end else if (func == FN_FOLD && !is_empty) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_POP: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (hit || last_cmp) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory control, queue pointers and result word
  always_comb begin
    mctl             = '0;
    rd_addr          = head;
    wr_addr          = tail;
    wr_type          = event_type;
    wr_target        = event_target;
    wr_payload       = event_payload;
    head_next        = head;
    tail_next        = tail;
    occ_next         = occ;
    pos_next         = pos;
    cnt_next         = cnt;
    done_next        = 1'b0;
    status_next      = STAT_OK;
    out_type_next    = '0;
    out_target_next  = '0;
    out_payload_next = '0;
    merged_next      = 1'b0;
    dropped_next     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FN_POST: begin
              done_next = 1'b1;
              if (is_full) begin
                status_next = STAT_FULL;
              end else begin
                mctl.wr_all = 1'b1;
                tail_next   = wrap_inc(tail);
                occ_next    = CNT_W'(occ + 1'b1);
              end
            end
            FN_FOLD: begin
              if (is_empty) begin
                // nothing to match against: plain append
                done_next   = 1'b1;
                mctl.wr_all = 1'b1;
                tail_next   = wrap_inc(tail);
                occ_next    = CNT_W'(occ + 1'b1);
              end else begin
                mctl.rd_en = 1'b1;
                rd_addr    = head;
                pos_next   = head;
                cnt_next   = '0;
              end
            end
            FN_POP: begin
              if (is_empty) begin
                done_next   = 1'b1;
                status_next = STAT_EMPTY;
              end else begin
                mctl.rd_en = 1'b1;
                rd_addr    = head;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        done_next        = 1'b1;
        out_type_next    = rd_type;
        out_target_next  = rd_target;
        out_payload_next = rd_payload;
        head_next        = wrap_inc(head);
        occ_next         = CNT_W'(occ - 1'b1);
      end
      ST_SCAN: begin
        wr_type    = cmd_type;
        wr_target  = cmd_target;
        wr_payload = cmd_payload;
        if (hit) begin
          // oldest match: overwrite its payload
          done_next   = 1'b1;
          merged_next = 1'b1;
          mctl.wr_pay = 1'b1;
          wr_addr     = pos;
        end else if (last_cmp) begin
          done_next = 1'b1;
          if (is_full) begin
            dropped_next = 1'b1;
          end else begin
            mctl.wr_all = 1'b1;
            wr_addr     = tail;
            tail_next   = wrap_inc(tail);
            occ_next    = CNT_W'(occ + 1'b1);
          end
        end else begin
          mctl.rd_en = 1'b1;
          pos_next   = wrap_inc(pos);
          rd_addr    = wrap_inc(pos);
          cnt_next   = CNT_W'(cnt + 1'b1);
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      occ   <= occ_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos         <= pos_next;
    cnt         <= cnt_next;
    status      <= status_next;
    out_type    <= out_type_next;
    out_target  <= out_target_next;
    out_payload <= out_payload_next;
    merged      <= merged_next;
    dropped     <= dropped_next;
    if (accept) begin
      cmd_type    <= event_type;
      cmd_target  <= event_target;
      cmd_payload <= event_payload;
    end
  end

`ifndef NO_ASSERTIONS
  // every accepted command either answers next cycle or holds busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted command neither answered nor busy");

  // a drop only happens when the queue is full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> is_full)
    else $error("fold dropped with free slots");

  // merge and drop are exclusive and leave status ok
  a_merge_ok: assert property (@(posedge clk) disable iff (rst)
    (done && merged) |-> (!dropped && status == STAT_OK))
    else $error("merge result malformed");

  // occupancy stays within the queue depth
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_CNT)
    else $error("occupancy overflow");
`endif

endmodule
